// ===== rtl/pru_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel replicate upscaler package
// Shared constants, codes and the command record passed from front to back.
// ----------------------------------------------------------------------------
package pru_pkg;

   localparam int PIXEL_W       = 24;
   localparam int SCALE_W       = 7;
   localparam int ROW_WIDTH_W   = 12;
   localparam int PAD_W         = 2;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 12;
   localparam int QUEUE_DEPTH   = 4;

   localparam int MAX_ROW_WIDTH_DEFAULT = 2048;
   localparam int MAX_SCALE_DEFAULT     = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_FACTOR = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_WIDTH    = 1'b1;

   localparam logic REQ_PIXEL  = 1'b0;
   localparam logic REQ_REPLAY = 1'b1;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [SCALE_W-1:0] count;
      logic               ends_row;
      logic [PAD_W-1:0]   pad;
      logic               error;
   } cmd_type;

endpackage

// ===== rtl/pru_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, either a write or a read, with registered read data.
// ----------------------------------------------------------------------------
module pru_ram #(
   parameter int DATA_W = 24,
   parameter int DEPTH  = 2048,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (wr_en) begin
            mem_ff[addr] <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pru_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel replicate upscaler front end
// Holds the configuration, accepts requests, checks their phase, keeps the
// column and replay counters and the line store, and issues commands.
// ----------------------------------------------------------------------------
module pru_front #(
   parameter int MAX_ROW_WIDTH = pru_pkg::MAX_ROW_WIDTH_DEFAULT,
   parameter int MAX_SCALE     = pru_pkg::MAX_SCALE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [pru_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pru_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic [pru_pkg::PIXEL_W-1:0]      req_pixel_in,
   output logic                             push_valid,
   input  logic                             push_ready,
   output pru_pkg::cmd_type                 push_data
);

   localparam int COL_W = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
   localparam int RPL_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
   localparam int EW    = ($clog2(MAX_ROW_WIDTH + 1) > pru_pkg::ROW_WIDTH_W) ?
                          $clog2(MAX_ROW_WIDTH + 1) : pru_pkg::ROW_WIDTH_W;

   logic [pru_pkg::SCALE_W-1:0]     scale_ff, scale_in;
   logic [pru_pkg::ROW_WIDTH_W-1:0] width_ff, width_in;
   logic [COL_W-1:0]                column_ff, column_in;
   logic [RPL_W-1:0]                replays_ff, replays_in;
   logic                            s1_valid_ff, s1_valid_in;
   logic                            s1_use_ram_ff, s1_use_ram_in;
   pru_pkg::cmd_type                s1_cmd_ff, s1_cmd_in;

   logic [pru_pkg::SCALE_W-1:0]     s_eff;
   logic [EW-1:0]                   w_eff;
   logic [EW-1:0]                   column_next;
   logic                            req_accept;
   logic                            phase_error;
   logic                            ends_row;
   logic [pru_pkg::PAD_W-1:0]       pad_low;
   logic                            ram_en;
   logic [pru_pkg::PIXEL_W-1:0]     ram_rd_data;

   always_comb begin
      if (scale_ff == '0) begin
         s_eff = pru_pkg::SCALE_W'(1);
      end else if (scale_ff > pru_pkg::SCALE_W'(MAX_SCALE)) begin
         s_eff = pru_pkg::SCALE_W'(MAX_SCALE);
      end else begin
         s_eff = scale_ff;
      end
      if (width_ff == '0) begin
         w_eff = EW'(1);
      end else if (EW'(width_ff) > EW'(MAX_ROW_WIDTH)) begin
         w_eff = EW'(MAX_ROW_WIDTH);
      end else begin
         w_eff = EW'(width_ff);
      end
   end

   assign req_ready   = !s1_valid_ff || push_ready;
   assign req_accept  = req_valid && req_ready;
   assign phase_error = ((req_type == pru_pkg::REQ_PIXEL) && (replays_ff != '0)) ||
                        ((req_type == pru_pkg::REQ_REPLAY) && (replays_ff == '0));
   assign column_next = EW'(column_ff) + EW'(1);
   assign ends_row    = (column_next >= w_eff);
   assign pad_low     = pru_pkg::PAD_W'(s_eff[pru_pkg::PAD_W-1:0] *
                                        w_eff[pru_pkg::PAD_W-1:0]);
   assign ram_en      = req_accept && !phase_error;

   always_comb begin
      scale_in      = scale_ff;
      width_in      = width_ff;
      column_in     = column_ff;
      replays_in    = replays_ff;
      s1_valid_in   = s1_valid_ff;
      s1_use_ram_in = s1_use_ram_ff;
      s1_cmd_in     = s1_cmd_ff;

      if (csr_write_enable) begin
         case (csr_index)
            pru_pkg::CSR_SCALE_FACTOR: scale_in = csr_write_data[pru_pkg::SCALE_W-1:0];
            pru_pkg::CSR_ROW_WIDTH:    width_in = csr_write_data[pru_pkg::ROW_WIDTH_W-1:0];
            default: ;
         endcase
      end

      if (req_accept) begin
         s1_valid_in = 1'b1;
         if (phase_error) begin
            s1_use_ram_in      = 1'b0;
            s1_cmd_in.pixel    = '0;
            s1_cmd_in.count    = pru_pkg::SCALE_W'(1);
            s1_cmd_in.ends_row = 1'b0;
            s1_cmd_in.pad      = '0;
            s1_cmd_in.error    = 1'b1;
         end else begin
            s1_use_ram_in      = (req_type == pru_pkg::REQ_REPLAY);
            s1_cmd_in.pixel    = req_pixel_in;
            s1_cmd_in.count    = s_eff;
            s1_cmd_in.ends_row = ends_row;
            s1_cmd_in.pad      = ends_row ? pad_low : '0;
            s1_cmd_in.error    = 1'b0;
            if (ends_row) begin
               column_in = '0;
               if (req_type == pru_pkg::REQ_PIXEL) begin
                  replays_in = RPL_W'(s_eff - pru_pkg::SCALE_W'(1));
               end else begin
                  replays_in = replays_ff - RPL_W'(1);
               end
            end else begin
               column_in = column_next[COL_W-1:0];
            end
         end
      end else if (push_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff    <= pru_pkg::SCALE_W'(1);
         width_ff    <= pru_pkg::ROW_WIDTH_W'(1);
         column_ff   <= '0;
         replays_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         scale_ff    <= scale_in;
         width_ff    <= width_in;
         column_ff   <= column_in;
         replays_ff  <= replays_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_use_ram_ff <= s1_use_ram_in;
      s1_cmd_ff     <= s1_cmd_in;
   end

   pru_ram #(
      .DATA_W (pru_pkg::PIXEL_W),
      .DEPTH  (MAX_ROW_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .en      (ram_en),
      .wr_en   (req_type == pru_pkg::REQ_PIXEL),
      .addr    (column_ff),
      .wr_data (req_pixel_in),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      push_data = s1_cmd_ff;
      if (s1_use_ram_ff) begin
         push_data.pixel = ram_rd_data;
      end
   end

   assign push_valid = s1_valid_ff;

endmodule

// ===== rtl/pru_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel replicate upscaler command queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module pru_queue #(
   parameter int WIDTH = $bits(pru_pkg::cmd_type),
   parameter int DEPTH = pru_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_ready && out_valid;
   assign out_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== rtl/pru_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel replicate upscaler back end
// Expands each command into its run of replicated pixels, one per cycle unless
// the response port stalls, through a registered response stage.
// ----------------------------------------------------------------------------
module pru_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  pru_pkg::cmd_type              cmd_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pru_pkg::PIXEL_W-1:0]   rsp_pixel_out,
   output logic                          rsp_row_end,
   output logic [pru_pkg::PAD_W-1:0]     rsp_pad_bytes,
   output logic                          rsp_run_last,
   output logic                          rsp_error_flag
);

   pru_pkg::cmd_type              cur_ff, cur_in;
   logic [pru_pkg::SCALE_W-1:0]   remain_ff, remain_in;
   logic                          valid_ff, valid_in;
   logic [pru_pkg::PIXEL_W-1:0]   pixel_ff, pixel_in;
   logic                          row_end_ff, row_end_in;
   logic [pru_pkg::PAD_W-1:0]     pad_ff, pad_in;
   logic                          last_ff, last_in;
   logic                          error_ff, error_in;

   logic                          load;
   logic                          busy;
   logic                          emit;
   pru_pkg::cmd_type              src;
   logic [pru_pkg::SCALE_W-1:0]   src_remain;
   logic                          src_last;

   assign load      = !valid_ff || rsp_ready;
   assign busy      = (remain_ff != '0);
   assign cmd_ready = load && !busy;
   assign emit      = load && (busy || cmd_valid);
   assign src       = busy ? cur_ff : cmd_data;
   assign src_remain = busy ? remain_ff : cmd_data.count;
   assign src_last  = (src_remain == pru_pkg::SCALE_W'(1));

   always_comb begin
      cur_in     = cur_ff;
      remain_in  = remain_ff;
      valid_in   = valid_ff;
      pixel_in   = pixel_ff;
      row_end_in = row_end_ff;
      pad_in     = pad_ff;
      last_in    = last_ff;
      error_in   = error_ff;
      if (emit) begin
         cur_in     = src;
         remain_in  = src_remain - pru_pkg::SCALE_W'(1);
         valid_in   = 1'b1;
         pixel_in   = src.pixel;
         row_end_in = src_last && src.ends_row;
         pad_in     = src_last ? src.pad : '0;
         last_in    = src_last;
         error_in   = src.error;
      end else if (load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         remain_ff <= remain_in;
         valid_ff  <= valid_in;
      end
      cur_ff     <= cur_in;
      pixel_ff   <= pixel_in;
      row_end_ff <= row_end_in;
      pad_ff     <= pad_in;
      last_ff    <= last_in;
      error_ff   <= error_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_pixel_out  = pixel_ff;
   assign rsp_row_end    = row_end_ff;
   assign rsp_pad_bytes  = pad_ff;
   assign rsp_run_last   = last_ff;
   assign rsp_error_flag = error_ff;

endmodule

// ===== rtl/pixel_replicate_upscaler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel replicate upscaler
// Integer nearest-neighbour upscaler for 24-bit pixels with a line store.
// ----------------------------------------------------------------------------
// A request is accepted in every cycle that the command queue has room, and
// each pixel or replay request yields scale_factor responses (zero counts as
// one, values above MAX_SCALE as MAX_SCALE), one per cycle at the response
// port while it is ready; a wrong-phase request yields a single error response.
// The response port sets this pace, and later requests wait in the command queue.
// The first response of a request passes through the single-port line store
// read and the command register, then the command queue, then the response
// register.
module pixel_replicate_upscaler #(
   parameter int MAX_ROW_WIDTH = pru_pkg::MAX_ROW_WIDTH_DEFAULT,
   parameter int MAX_SCALE     = pru_pkg::MAX_SCALE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [pru_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pru_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic [pru_pkg::PIXEL_W-1:0]      req_pixel_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pru_pkg::PIXEL_W-1:0]      rsp_pixel_out,
   output logic                             rsp_row_end,
   output logic [pru_pkg::PAD_W-1:0]        rsp_pad_bytes,
   output logic                             rsp_run_last,
   output logic                             rsp_error_flag
);

   logic             push_valid;
   logic             push_ready;
   pru_pkg::cmd_type push_data;
   logic             pop_valid;
   logic             pop_ready;
   pru_pkg::cmd_type pop_data;

   pru_front #(
      .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
      .MAX_SCALE     (MAX_SCALE)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_pixel_in     (req_pixel_in),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   pru_queue #(
      .WIDTH ($bits(pru_pkg::cmd_type)),
      .DEPTH (pru_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   pru_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (pop_valid),
      .cmd_ready      (pop_ready),
      .cmd_data       (pop_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_row_end    (rsp_row_end),
      .rsp_pad_bytes  (rsp_pad_bytes),
      .rsp_run_last   (rsp_run_last),
      .rsp_error_flag (rsp_error_flag)
   );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel replicate upscaler testbench
// A table of directed requests is followed by random row and replay
// sequences, with some out-of-phase noise. Scale and width are changed
// between phases. A predictor in the bench computes each response that the
// table omits; all are checked in order while both ports idle at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int TARGET_REQUESTS = 350;
   localparam int CYCLE_LIMIT     = 2000000;
   localparam int SETTLE_CYCLES   = 16;
   localparam int PLAN_LEN        = 28;

   typedef struct packed {
      logic [pru_pkg::PIXEL_W-1:0] pixel;
      logic                        row_end;
      logic [pru_pkg::PAD_W-1:0]   pad;
      logic                        run_last;
      logic                        error;
   } result_type;

   typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_type;

   typedef struct packed {
      row_kind_type                    kind;
      logic [pru_pkg::CSR_INDEX_W-1:0] csr_sel;
      logic [pru_pkg::CSR_DATA_W-1:0]  csr_value;
      logic                            req_kind;
      logic [pru_pkg::PIXEL_W-1:0]     pixel;
      logic                            typed;
      result_type                      typed_rsp;
   } plan_row_type;

   typedef enum logic [1:0] {FLOW_FREE, FLOW_CHOPPY, FLOW_CHOKED} flow_type;

   localparam result_type ERR_RSP = '{'0, 1'b0, 2'd0, 1'b1, 1'b1};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [pru_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pru_pkg::CSR_DATA_W-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = pru_pkg::REQ_PIXEL;
   logic [pru_pkg::PIXEL_W-1:0] req_pixel_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [pru_pkg::PIXEL_W-1:0] rsp_pixel_out;
   logic rsp_row_end;
   logic [pru_pkg::PAD_W-1:0] rsp_pad_bytes;
   logic rsp_run_last;
   logic rsp_error_flag;

   // Predictor state and register copies.
   logic [pru_pkg::PIXEL_W-1:0] row_store [0:pru_pkg::MAX_ROW_WIDTH_DEFAULT-1];
   logic [10:0] col_pos = '0;
   logic [5:0] replays_pending = '0;
   logic [pru_pkg::SCALE_W-1:0] scale_setting = 7'd1;
   logic [pru_pkg::ROW_WIDTH_W-1:0] width_setting = 12'd1;

   result_type step_results [0:pru_pkg::MAX_SCALE_DEFAULT-1];
   int step_count;
   result_type pending_pixels [$];

   plan_row_type plan [0:PLAN_LEN-1];
   int burst_left;
   int requests_sent = 0;
   int pixel_count = 0;
   int replay_count = 0;
   int wrong_phase_count = 0;
   int response_count = 0;
   int register_writes = 0;
   int error_count = 0;
   int cycle_count = 0;
   flow_type flow_mode = FLOW_FREE;
   int flow_left = 0;

   pixel_replicate_upscaler uut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_pixel_in    (req_pixel_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_row_end     (rsp_row_end),
      .rsp_pad_bytes   (rsp_pad_bytes),
      .rsp_run_last    (rsp_run_last),
      .rsp_error_flag  (rsp_error_flag)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycle_count, pending_pixels.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (flow_left == 0) begin
         case ($urandom_range(0, 3))
            0, 1: flow_mode = FLOW_FREE;
            2: flow_mode = FLOW_CHOPPY;
            default: flow_mode = FLOW_CHOKED;
         endcase
         flow_left = $urandom_range(8, 64);
      end else begin
         flow_left = flow_left - 1;
      end
      case (flow_mode)
         FLOW_FREE: rsp_ready = 1'b1;
         FLOW_CHOPPY: rsp_ready = 1'($urandom_range(0, 1));
         default: rsp_ready = ($urandom_range(0, 5) == 0);
      endcase
   end

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_pixel_out, rsp_row_end, rsp_pad_bytes, rsp_run_last, rsp_error_flag};
         response_count = response_count + 1;
         if (pending_pixels.size() == 0) begin
            error_count = error_count + 1;
            $display("%0t: unexpected response pixel=%06h row_end=%0b pad=%0d last=%0b err=%0b",
                     $time, seen.pixel, seen.row_end, seen.pad, seen.run_last, seen.error);
         end else begin
            want = pending_pixels.pop_front();
            if (seen !== want) begin
               error_count = error_count + 1;
               $display("%0t: expected pixel=%06h row_end=%0b pad=%0d last=%0b err=%0b",
                        $time, want.pixel, want.row_end, want.pad, want.run_last, want.error);
               $display("%0t:   actual pixel=%06h row_end=%0b pad=%0d last=%0b err=%0b",
                        $time, seen.pixel, seen.row_end, seen.pad, seen.run_last, seen.error);
            end
         end
      end
   end

   function automatic int eff_scale(logic [pru_pkg::SCALE_W-1:0] value);
      if (value == 0) return 1;
      if (value > pru_pkg::MAX_SCALE_DEFAULT) return pru_pkg::MAX_SCALE_DEFAULT;
      return int'(value);
   endfunction

   function automatic int eff_width(logic [pru_pkg::ROW_WIDTH_W-1:0] value);
      if (value == 0) return 1;
      if (value > pru_pkg::MAX_ROW_WIDTH_DEFAULT) return pru_pkg::MAX_ROW_WIDTH_DEFAULT;
      return int'(value);
   endfunction

   function automatic plan_row_type csr_row(logic [pru_pkg::CSR_INDEX_W-1:0] sel,
                                            logic [pru_pkg::CSR_DATA_W-1:0] value);
      csr_row = '{ROW_WRITE, sel, value, pru_pkg::REQ_PIXEL, '0, 1'b0, '0};
   endfunction

   function automatic plan_row_type req_row(logic kind, logic [pru_pkg::PIXEL_W-1:0] pix);
      req_row = '{ROW_REQUEST, '0, '0, kind, pix, 1'b0, '0};
   endfunction

   function automatic plan_row_type typed_row(logic kind, logic [pru_pkg::PIXEL_W-1:0] pix,
                                              result_type rsp);
      typed_row = '{ROW_REQUEST, '0, '0, kind, pix, 1'b1, rsp};
   endfunction

   // Works out the responses to one accepted request and advances the state.
   task automatic upscale_step(input logic kind, input logic [pru_pkg::PIXEL_W-1:0] pix);
      int s;
      int w;
      logic [pru_pkg::PIXEL_W-1:0] p;
      logic ends;
      logic last;
      logic [pru_pkg::PAD_W-1:0] pad;
      s = eff_scale(scale_setting);
      w = eff_width(width_setting);
      if ((kind == pru_pkg::REQ_PIXEL) == (replays_pending != 0)) begin
         step_results[0] = ERR_RSP;
         step_count = 1;
         wrong_phase_count = wrong_phase_count + 1;
      end else begin
         if (kind == pru_pkg::REQ_PIXEL) begin
            row_store[col_pos] = pix;
            p = pix;
         end else begin
            p = row_store[col_pos];
         end
         ends = (int'(col_pos) + 1 >= w);
         pad = ends ? pru_pkg::PAD_W'(s * w) : 2'd0;
         for (int k = 0; k < s; k++) begin
            last = (k == s - 1);
            step_results[k] = '{p, last && ends, last ? pad : 2'd0, last, 1'b0};
         end
         step_count = s;
         if (ends) begin
            col_pos = '0;
            replays_pending = (kind == pru_pkg::REQ_PIXEL) ? 6'(s - 1) :
                              replays_pending - 6'd1;
         end else begin
            col_pos = col_pos + 11'd1;
         end
      end
   endtask

   task automatic send_request(input logic kind, input logic [pru_pkg::PIXEL_W-1:0] pix,
                               input logic typed, input result_type typed_rsp);
      req_type = kind;
      req_pixel_in = pix;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      upscale_step(kind, pix);
      if (typed) begin
         pending_pixels.push_back(typed_rsp);
      end else begin
         for (int k = 0; k < step_count; k++) pending_pixels.push_back(step_results[k]);
      end
      requests_sent = requests_sent + 1;
      if (kind == pru_pkg::REQ_PIXEL) pixel_count = pixel_count + 1;
      else replay_count = replay_count + 1;
      @(negedge clock);
      burst_left = burst_left - 1;
      if (burst_left <= 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 24);
      end
   endtask

   task automatic drain_responses;
      req_valid = 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [pru_pkg::CSR_INDEX_W-1:0] sel,
                                 input logic [pru_pkg::CSR_DATA_W-1:0] value);
      drain_responses();
      csr_write_enable = 1'b1;
      csr_index = sel;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (sel == pru_pkg::CSR_SCALE_FACTOR) scale_setting = value[pru_pkg::SCALE_W-1:0];
      else width_setting = value[pru_pkg::ROW_WIDTH_W-1:0];
      register_writes = register_writes + 1;
   endtask

   initial begin
      logic [pru_pkg::SCALE_W-1:0] next_scale;
      logic [pru_pkg::ROW_WIDTH_W-1:0] next_width;
      logic wrong;
      plan = '{
         typed_row(pru_pkg::REQ_REPLAY, 24'h13579B, ERR_RSP),
         typed_row(pru_pkg::REQ_PIXEL, 24'hFFFFFF, '{24'hFFFFFF, 1'b1, 2'd1, 1'b1, 1'b0}),
         typed_row(pru_pkg::REQ_PIXEL, 24'h000000, '{24'h000000, 1'b1, 2'd1, 1'b1, 1'b0}),
         csr_row(pru_pkg::CSR_SCALE_FACTOR, 12'd3),
         csr_row(pru_pkg::CSR_ROW_WIDTH, 12'd2),
         req_row(pru_pkg::REQ_PIXEL, 24'hFFFFFF),
         typed_row(pru_pkg::REQ_REPLAY, 24'hFFFFFF, ERR_RSP),
         req_row(pru_pkg::REQ_PIXEL, 24'h000001),
         typed_row(pru_pkg::REQ_PIXEL, 24'h800000, ERR_RSP),
         req_row(pru_pkg::REQ_REPLAY, 24'h000000),
         csr_row(pru_pkg::CSR_SCALE_FACTOR, 12'hF7F),
         req_row(pru_pkg::REQ_REPLAY, 24'hFFFFFF),
         req_row(pru_pkg::REQ_REPLAY, 24'h7FFFFF),
         req_row(pru_pkg::REQ_REPLAY, 24'h000000),
         csr_row(pru_pkg::CSR_SCALE_FACTOR, 12'h000),
         csr_row(pru_pkg::CSR_ROW_WIDTH, 12'h000),
         typed_row(pru_pkg::REQ_PIXEL, 24'h00FF00, '{24'h00FF00, 1'b1, 2'd1, 1'b1, 1'b0}),
         csr_row(pru_pkg::CSR_ROW_WIDTH, 12'hFFF),
         csr_row(pru_pkg::CSR_SCALE_FACTOR, 12'd2),
         req_row(pru_pkg::REQ_PIXEL, 24'h0000FF),
         req_row(pru_pkg::REQ_PIXEL, 24'hFF0000),
         csr_row(pru_pkg::CSR_ROW_WIDTH, 12'd2),
         req_row(pru_pkg::REQ_PIXEL, 24'h00AAAA),
         req_row(pru_pkg::REQ_REPLAY, 24'h000000),
         req_row(pru_pkg::REQ_REPLAY, 24'h000000),
         csr_row(pru_pkg::CSR_SCALE_FACTOR, 12'd64),
         csr_row(pru_pkg::CSR_ROW_WIDTH, 12'd1),
         req_row(pru_pkg::REQ_PIXEL, 24'h5A5A5A)
      };
      burst_left = $urandom_range(1, 24);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            write_register(plan[i].csr_sel, plan[i].csr_value);
         end else begin
            send_request(plan[i].req_kind, plan[i].pixel, plan[i].typed, plan[i].typed_rsp);
         end
      end

      // Random phases: mostly well-formed rows and replays, some out-of-phase noise.
      while (requests_sent < TARGET_REQUESTS) begin
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 15))
               0: next_scale = 7'd64;
               1: next_scale = 7'd0;
               2: next_scale = 7'($urandom_range(65, 127));
               3: next_scale = 7'($urandom_range(7, 63));
               default: next_scale = 7'($urandom_range(1, 6));
            endcase
            write_register(pru_pkg::CSR_SCALE_FACTOR, {5'($urandom), next_scale});
         end
         if ($urandom_range(0, 1)) begin
            if (eff_scale(scale_setting) > 8) begin
               next_width = 12'($urandom_range(1, 2));
            end else begin
               case ($urandom_range(0, 15))
                  0: next_width = 12'd0;
                  1: next_width = 12'($urandom_range(2049, 4095));
                  2: next_width = 12'd2048;
                  3: next_width = 12'($urandom_range(9, 2047));
                  default: next_width = 12'($urandom_range(1, 8));
               endcase
            end
            // While replay rows are pending the width may only shrink, so that
            // every replay reads a line store entry that has been written.
            if (replays_pending == 0 || eff_width(next_width) <= eff_width(width_setting)) begin
               write_register(pru_pkg::CSR_ROW_WIDTH, next_width);
            end
         end
         repeat ($urandom_range(4, 40)) begin
            wrong = ($urandom_range(0, 7) == 0);
            send_request(((replays_pending != 0) ^ wrong) ? pru_pkg::REQ_REPLAY :
                         pru_pkg::REQ_PIXEL, pru_pkg::PIXEL_W'($urandom), 1'b0, '0);
         end
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d requests: %0d pixels, %0d replays, %0d of them out of phase.",
               requests_sent, pixel_count, replay_count, wrong_phase_count);
      $display("Checked %0d responses across %0d scale and width register writes.",
               response_count, register_writes);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
